// ===== hdl/atm_pkg.sv =====
// shared types, constants and the arctangent table for the tilt and moving-average block
package atm_pkg;

	// angle accumulator: degrees with 16 fraction bits
	localparam int ACC_FRAC = 16;
	localparam int ACC_W = 26;
	localparam int PRE_SHIFT = 12;
	localparam int CORDIC_ITERS = 16;
	localparam int ITER_W = 4;
	localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(CORDIC_ITERS - 1);
	localparam logic signed [ACC_W-1:0] ANGLE_90 = ACC_W'(90 <<< ACC_FRAC);

	// gain compensation: round(2^24 / K), applied in 16-bit slices of x
	localparam int MUL_CHUNK = 16;
	localparam int GAIN_W = 24;
	localparam logic [GAIN_W-1:0] INV_GAIN = 24'd10188014;
	localparam int MAG_SHIFT = 24;

	// busy and done flags of a multi-cycle unit
	typedef struct packed {
		logic busy;
		logic done;
	} unit_stat_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RING,
		ST_ROLL,
		ST_PITCH,
		ST_OUT
	} top_state_t;

	typedef enum logic [1:0] {
		CS_IDLE,
		CS_ITER,
		CS_MAG,
		CS_DONE
	} cordic_state_t;

	// round(atan(2^-i) degrees * 65536)
	function automatic logic signed [ACC_W-1:0] atan_entry(input logic [ITER_W-1:0] idx);
		logic signed [ACC_W-1:0] v;
		case (idx)
			4'd0: v = 26'sd2949120;
			4'd1: v = 26'sd1740967;
			4'd2: v = 26'sd919879;
			4'd3: v = 26'sd466945;
			4'd4: v = 26'sd234379;
			4'd5: v = 26'sd117304;
			4'd6: v = 26'sd58666;
			4'd7: v = 26'sd29335;
			4'd8: v = 26'sd14668;
			4'd9: v = 26'sd7334;
			4'd10: v = 26'sd3667;
			4'd11: v = 26'sd1833;
			4'd12: v = 26'sd917;
			4'd13: v = 26'sd458;
			4'd14: v = 26'sd229;
			4'd15: v = 26'sd115;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

// ===== hdl/atm_ring.sv =====
// sample ring memory with read-modify-write of the running sums
module atm_ring #(
	parameter int WINDOW_LEN = 8,
	parameter int SUM_W = 19,
	parameter int CNT_W = 4
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic signed [15:0]      sample_x,
	input  logic signed [15:0]      sample_y,
	input  logic signed [15:0]      sample_z,
	output logic signed [SUM_W-1:0] sum_x,
	output logic signed [SUM_W-1:0] sum_y,
	output logic signed [SUM_W-1:0] sum_z,
	output logic [CNT_W-1:0]        fill,
	output logic                    done
);
	localparam int SLOT_W = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
	localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW_LEN - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(WINDOW_LEN);

	logic [47:0] ring_mem [WINDOW_LEN];
	logic [47:0] rd_data_s1;
	logic [47:0] new_s1;
	logic upd_s1;
	logic done_q;
	logic [SLOT_W-1:0] slot_q;
	logic [CNT_W-1:0] fill_q;
	logic signed [SUM_W-1:0] sum_x_q, sum_y_q, sum_z_q;
	logic signed [15:0] old_x, old_y, old_z;
	logic full;

	// one read at the current slot, written back in the following cycle
	always_ff @(posedge clk) begin
		if (start) begin
			rd_data_s1 <= ring_mem[slot_q];
			new_s1 <= {sample_x, sample_y, sample_z};
		end
		if (upd_s1) begin
			ring_mem[slot_q] <= new_s1;
		end
	end

	// entries not yet written since reset read as zero
	assign full = (fill_q == FULL_CNT);
	always_comb begin
		old_x = full ? signed'(rd_data_s1[47:32]) : 16'sd0;
		old_y = full ? signed'(rd_data_s1[31:16]) : 16'sd0;
		old_z = full ? signed'(rd_data_s1[15:0]) : 16'sd0;
	end

	// sums, slot pointer and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upd_s1 <= 1'b0;
			done_q <= 1'b0;
			slot_q <= '0;
			fill_q <= '0;
			sum_x_q <= '0;
			sum_y_q <= '0;
			sum_z_q <= '0;
		end else begin
			upd_s1 <= start;
			done_q <= upd_s1;
			if (upd_s1) begin
				sum_x_q <= sum_x_q + SUM_W'(signed'(new_s1[47:32])) - SUM_W'(old_x);
				sum_y_q <= sum_y_q + SUM_W'(signed'(new_s1[31:16])) - SUM_W'(old_y);
				sum_z_q <= sum_z_q + SUM_W'(signed'(new_s1[15:0])) - SUM_W'(old_z);
				slot_q <= (slot_q == LAST_SLOT) ? '0 : slot_q + 1'b1;
				if (!full) begin
					fill_q <= fill_q + 1'b1;
				end
			end
		end
	end

	assign sum_x = sum_x_q;
	assign sum_y = sum_y_q;
	assign sum_z = sum_z_q;
	assign fill = fill_q;
	assign done = done_q;

endmodule

// ===== hdl/atm_div.sv =====
// bit-serial restoring divider for one axis mean, truncating toward zero
module atm_div import atm_pkg::*; #(
	parameter int SUM_W = 19,
	parameter int CNT_W = 4
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic signed [SUM_W-1:0] dividend,
	input  logic [CNT_W-1:0]        divisor,
	output logic signed [15:0]      quotient,
	output unit_stat_t              stat
);
	localparam int STEP_W = $clog2(SUM_W + 1);

	logic [SUM_W-1:0] dvd_q;
	logic [CNT_W-1:0] rem_q;
	logic [CNT_W-1:0] dvs_q;
	logic neg_q;
	logic [STEP_W-1:0] step_q;
	logic busy_q;
	logic done_q;
	logic [SUM_W-1:0] mag_in;
	logic [SUM_W-1:0] q_signed;
	logic [CNT_W:0] trial;
	logic [CNT_W:0] diff;
	logic fits;

	assign mag_in = dividend[SUM_W-1] ? (~dividend + 1'b1) : dividend;

	// one quotient bit per cycle
	always_comb begin
		trial = {rem_q, dvd_q[SUM_W-1]};
		diff = trial - {1'b0, dvs_q};
		fits = (trial >= {1'b0, dvs_q});
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= mag_in;
			rem_q <= '0;
			dvs_q <= divisor;
			neg_q <= dividend[SUM_W-1];
		end else if (busy_q) begin
			dvd_q <= {dvd_q[SUM_W-2:0], fits};
			rem_q <= fits ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= STEP_W'(SUM_W);
			end else if (busy_q) begin
				step_q <= step_q - 1'b1;
				if (step_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// restore the sign and keep the low 16 bits
	assign q_signed = neg_q ? (~dvd_q + 1'b1) : dvd_q;
	assign quotient = signed'(q_signed[15:0]);
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

// ===== hdl/atm_cordic.sv =====
// shared vectoring cordic with serial gain-compensation multiply
module atm_cordic import atm_pkg::*; #(
	parameter int XW = 33
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic signed [XW-1:0]    x_in,
	input  logic signed [XW-1:0]    y_in,
	output logic signed [ACC_W-1:0] angle,
	output logic [XW-1:0]           mag,
	output unit_stat_t              stat
);
	localparam int NCH = (XW + MUL_CHUNK - 1) / MUL_CHUNK;
	localparam int PAD_W = NCH * MUL_CHUNK;
	localparam int PROD_W = PAD_W + GAIN_W;
	localparam int CH_W = $clog2(NCH + 1);
	localparam logic [PROD_W-1:0] MAG_ROUND = PROD_W'(1) << (MAG_SHIFT - 1);

	cordic_state_t state_q, state_d;
	logic signed [XW-1:0] x_q, y_q;
	logic signed [ACC_W-1:0] acc_q;
	logic [ITER_W-1:0] iter_q;
	logic zero_q;
	logic [PAD_W-1:0] mul_q;
	logic [PROD_W-1:0] prod_q;
	logic [CH_W-1:0] chunk_q;
	logic signed [XW-1:0] x0, y0, x_nx, y_nx, dx, dy;
	logic signed [ACC_W-1:0] acc0, acc_nx;
	logic [XW-1:0] x_pos;
	logic [MUL_CHUNK+GAIN_W-1:0] part;
	logic [PROD_W-1:0] rnd;

	// quarter turn into the right half plane
	always_comb begin
		if (x_in[XW-1]) begin
			if (!y_in[XW-1]) begin
				x0 = y_in;
				y0 = -x_in;
				acc0 = ANGLE_90;
			end else begin
				x0 = -y_in;
				y0 = x_in;
				acc0 = -ANGLE_90;
			end
		end else begin
			x0 = x_in;
			y0 = y_in;
			acc0 = '0;
		end
	end

	// one micro-rotation toward y = 0
	always_comb begin
		dx = y_q >>> iter_q;
		dy = x_q >>> iter_q;
		if (!y_q[XW-1]) begin
			x_nx = x_q + dx;
			y_nx = y_q - dy;
			acc_nx = acc_q + atan_entry(iter_q);
		end else begin
			x_nx = x_q - dx;
			y_nx = y_q + dy;
			acc_nx = acc_q - atan_entry(iter_q);
		end
		x_pos = x_nx[XW-1] ? '0 : unsigned'(x_nx);
		part = mul_q[PAD_W-1 -: MUL_CHUNK] * INV_GAIN;
	end

	// next state
	always_comb begin
		case (state_q)
			CS_IDLE: state_d = start ? CS_ITER : CS_IDLE;
			CS_ITER: state_d = (iter_q == ITER_LAST) ? CS_MAG : CS_ITER;
			CS_MAG: state_d = (chunk_q == CH_W'(1)) ? CS_DONE : CS_MAG;
			CS_DONE: state_d = start ? CS_ITER : CS_IDLE;
			default: state_d = CS_IDLE;
		endcase
	end

	// status outputs
	always_comb begin
		stat.busy = (state_q == CS_ITER) || (state_q == CS_MAG);
		stat.done = (state_q == CS_DONE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CS_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// datapath: load, rotate, then multiply by the inverse gain a slice at a time
	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= x0;
			y_q <= y0;
			acc_q <= acc0;
			iter_q <= '0;
			zero_q <= (x_in == '0) && (y_in == '0);
		end else if (state_q == CS_ITER) begin
			x_q <= x_nx;
			y_q <= y_nx;
			acc_q <= acc_nx;
			iter_q <= iter_q + 1'b1;
			if (iter_q == ITER_LAST) begin
				mul_q <= PAD_W'(x_pos);
				prod_q <= '0;
				chunk_q <= CH_W'(NCH);
			end
		end else if (state_q == CS_MAG) begin
			prod_q <= (prod_q << MUL_CHUNK) + PROD_W'(part);
			mul_q <= mul_q << MUL_CHUNK;
			chunk_q <= chunk_q - 1'b1;
		end
	end

	assign rnd = prod_q + MAG_ROUND;
	assign mag = zero_q ? '0 : rnd[MAG_SHIFT +: XW];
	assign angle = zero_q ? '0 : acc_q;

endmodule

// ===== hdl/accel_tilt_moving_average_core.sv =====
// top level: moving-average means and roll/pitch tilt from a 3-axis accelerometer
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  in      | in_valid, in_ready, sample_x/y/z          | into block
//  out     | out_valid, out_ready, mean_x/y/z,         | out of block
//          | roll_angle, pitch_angle, samples_in_window|
//
// each beat runs the ring read and write-back, two passes of the shared cordic (16 steps,
// three gain-multiply slices and a done state per pass), the output load and a return
// to idle; the three mean dividers run alongside, and a new sample is taken only in idle.
// reset clears the sums, fill count and slot pointer; ring entries not yet written
// since reset read as zero through the fill count, so no clearing pass is needed.
// a finished beat waits in the output register while the next input is taken.
module accel_tilt_moving_average_core import atm_pkg::*; #(
	parameter int WINDOW_LEN = 8,
	parameter int ANGLE_FRAC_BITS = 7
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [15:0] sample_x,
	input  logic signed [15:0] sample_y,
	input  logic signed [15:0] sample_z,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [15:0] mean_x,
	output logic signed [15:0] mean_y,
	output logic signed [15:0] mean_z,
	output logic signed [15:0] roll_angle,
	output logic signed [14:0] pitch_angle,
	output logic [3:0]         samples_in_window
);
	localparam int SUM_W = 16 + $clog2(WINDOW_LEN);
	localparam int CNT_W = $clog2(WINDOW_LEN + 1);
	localparam int XW = SUM_W + PRE_SHIFT + 2;
	localparam int RND_SHIFT = ACC_FRAC - ANGLE_FRAC_BITS;
	localparam logic [ACC_W-1:0] HALF = ACC_W'(1) << (RND_SHIFT - 1);
	localparam logic signed [ACC_W-1:0] ROLL_LIM = ACC_W'(180 <<< ANGLE_FRAC_BITS);
	localparam logic signed [ACC_W-1:0] PITCH_LIM = ACC_W'(90 <<< ANGLE_FRAC_BITS);

	top_state_t state_q, state_d;
	logic ring_start, ring_done, div_start, cor_start, out_load;
	logic signed [SUM_W-1:0] sum_x, sum_y, sum_z;
	logic [CNT_W-1:0] fill;
	logic signed [15:0] quo_x, quo_y, quo_z;
	unit_stat_t div_stat_x, div_stat_y, div_stat_z, cor_stat;
	logic div_busy;
	logic signed [XW-1:0] cor_x, cor_y;
	logic signed [ACC_W-1:0] cor_angle, angle_fin;
	logic [XW-1:0] cor_mag;
	logic [CNT_W+3:0] fill_ext;
	logic out_valid_q;
	logic signed [15:0] roll_q;
	logic signed [14:0] pitch_q;
	logic signed [15:0] mean_x_q, mean_y_q, mean_z_q, roll_out_q;
	logic signed [14:0] pitch_out_q;
	logic [3:0] count_out_q;

	// round half away from zero to the output grid, then clamp
	function automatic logic signed [ACC_W-1:0] finish_angle(
		input logic signed [ACC_W-1:0] acc,
		input logic signed [ACC_W-1:0] lim
	);
		logic [ACC_W-1:0] amag;
		logic signed [ACC_W-1:0] r;
		amag = acc[ACC_W-1] ? unsigned'(-acc) : unsigned'(acc);
		amag = (amag + HALF) >> RND_SHIFT;
		r = acc[ACC_W-1] ? -signed'(amag) : signed'(amag);
		if (r > lim) r = lim;
		if (r < -lim) r = -lim;
		return r;
	endfunction

	atm_ring #(
		.WINDOW_LEN(WINDOW_LEN),
		.SUM_W(SUM_W),
		.CNT_W(CNT_W)
	) u_ring (
		.clk(clk),
		.arst_n(arst_n),
		.start(ring_start),
		.sample_x(sample_x),
		.sample_y(sample_y),
		.sample_z(sample_z),
		.sum_x(sum_x),
		.sum_y(sum_y),
		.sum_z(sum_z),
		.fill(fill),
		.done(ring_done)
	);

	atm_div #(.SUM_W(SUM_W), .CNT_W(CNT_W)) u_div_x (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(sum_x),
		.divisor(fill), .quotient(quo_x), .stat(div_stat_x)
	);
	atm_div #(.SUM_W(SUM_W), .CNT_W(CNT_W)) u_div_y (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(sum_y),
		.divisor(fill), .quotient(quo_y), .stat(div_stat_y)
	);
	atm_div #(.SUM_W(SUM_W), .CNT_W(CNT_W)) u_div_z (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(sum_z),
		.divisor(fill), .quotient(quo_z), .stat(div_stat_z)
	);

	// roll pass takes (z, y); pitch pass takes (magnitude, -x)
	always_comb begin
		if (state_q == ST_RING) begin
			cor_x = XW'(sum_z) <<< PRE_SHIFT;
			cor_y = XW'(sum_y) <<< PRE_SHIFT;
		end else begin
			cor_x = signed'(cor_mag);
			cor_y = -(XW'(sum_x) <<< PRE_SHIFT);
		end
	end

	atm_cordic #(.XW(XW)) u_cordic (
		.clk(clk),
		.arst_n(arst_n),
		.start(cor_start),
		.x_in(cor_x),
		.y_in(cor_y),
		.angle(cor_angle),
		.mag(cor_mag),
		.stat(cor_stat)
	);

	assign div_busy = div_stat_x.busy | div_stat_y.busy | div_stat_z.busy;
	assign angle_fin = finish_angle(cor_angle, (state_q == ST_ROLL) ? ROLL_LIM : PITCH_LIM);

	// next state
	always_comb begin
		case (state_q)
			ST_IDLE: state_d = in_valid ? ST_RING : ST_IDLE;
			ST_RING: state_d = ring_done ? ST_ROLL : ST_RING;
			ST_ROLL: state_d = cor_stat.done ? ST_PITCH : ST_ROLL;
			ST_PITCH: state_d = cor_stat.done ? ST_OUT : ST_PITCH;
			ST_OUT: state_d = out_load ? ST_IDLE : ST_OUT;
			default: state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		in_ready = (state_q == ST_IDLE);
		ring_start = in_valid && (state_q == ST_IDLE);
		div_start = ring_done && (state_q == ST_RING);
		cor_start = div_start || (cor_stat.done && (state_q == ST_ROLL));
		out_load = (state_q == ST_OUT) && !div_busy && (!out_valid_q || out_ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// angle capture and output register
	assign fill_ext = (CNT_W + 4)'(fill);
	always_ff @(posedge clk) begin
		if (cor_stat.done && (state_q == ST_ROLL)) begin
			roll_q <= angle_fin[15:0];
		end
		if (cor_stat.done && (state_q == ST_PITCH)) begin
			pitch_q <= angle_fin[14:0];
		end
		if (out_load) begin
			mean_x_q <= quo_x;
			mean_y_q <= quo_y;
			mean_z_q <= quo_z;
			roll_out_q <= roll_q;
			pitch_out_q <= pitch_q;
			count_out_q <= fill_ext[3:0];
		end
	end

	assign out_valid = out_valid_q;
	assign mean_x = mean_x_q;
	assign mean_y = mean_y_q;
	assign mean_z = mean_z_q;
	assign roll_angle = roll_out_q;
	assign pitch_angle = pitch_out_q;
	assign samples_in_window = count_out_q;

`ifndef NO_ASSERTIONS
	a_cor_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cor_start |-> !cor_stat.busy)
		else $error("cordic started while busy");
	a_ring_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		ring_done |-> state_q == ST_RING)
		else $error("ring update finished outside its wait state");
	a_accept_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |-> (!cor_stat.busy && !div_busy))
		else $error("beat accepted while a unit is still working");
`endif

endmodule

// ===== tb/tb_accel_tilt_moving_average_core.sv =====
// testbench for the accelerometer tilt and moving-average core
`timescale 1ns / 100ps

module tb_accel_tilt_moving_average_core;
	import atm_pkg::*;

	localparam int WIN = 8;
	localparam int AFRAC = 7;
	localparam longint GAIN_COMP = 10188014;

	typedef struct packed {
		logic signed [15:0] mx;
		logic signed [15:0] my;
		logic signed [15:0] mz;
		logic signed [15:0] roll;
		logic signed [14:0] pitch;
		logic [3:0]         fill;
	} tilt_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic signed [15:0] sample_x = '0;
	logic signed [15:0] sample_y = '0;
	logic signed [15:0] sample_z = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [15:0] mean_x, mean_y, mean_z, roll_angle;
	logic signed [14:0] pitch_angle;
	logic [3:0] samples_in_window;

	// predictor state
	longint hist_x [WIN];
	longint hist_y [WIN];
	longint hist_z [WIN];
	longint acc_x, acc_y, acc_z;
	int slot_ptr, held;

	tilt_result_t pending_tilt[$];
	int errors = 0;
	int beats_sent = 0;
	int beats_seen = 0;
	int burst_left = 0;
	bit stall_mode = 0;

	accel_tilt_moving_average_core dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic longint floor_shr(longint v, int s);
		return v >>> s;
	endfunction

	// vectoring cordic in 2^-16 degree, magnitude gain compensated
	function automatic longint cordic_angle(longint xi, longint yi, output longint mag);
		longint x, y, a, t, dx, dy;
		x = xi; y = yi; a = 0;
		if (x == 0 && y == 0) begin
			mag = 0;
			return 0;
		end
		if (x < 0) begin
			if (y >= 0) begin
				t = x; x = y; y = -t; a = 90 <<< 16;
			end else begin
				t = x; x = -y; y = t; a = -(90 <<< 16);
			end
		end
		for (int i = 0; i < CORDIC_ITERS; i++) begin
			dx = floor_shr(y, i);
			dy = floor_shr(x, i);
			if (y >= 0) begin
				x += dx; y -= dy; a += longint'(atan_entry(i[3:0]));
			end else begin
				x -= dx; y += dy; a -= longint'(atan_entry(i[3:0]));
			end
		end
		if (x < 0) x = 0;
		mag = (x * GAIN_COMP + (64'sd1 <<< 23)) >>> 24;
		return a;
	endfunction

	function automatic longint round_clamp(longint a, longint lim_deg);
		int s;
		longint r, lim;
		s = 16 - AFRAC;
		lim = lim_deg <<< AFRAC;
		if (a >= 0) r = (a + (64'sd1 <<< (s - 1))) >>> s;
		else r = -((-a + (64'sd1 <<< (s - 1))) >>> s);
		if (r > lim) r = lim;
		if (r < -lim) r = -lim;
		return r;
	endfunction

	task automatic predict_tilt(logic signed [15:0] sx, logic signed [15:0] sy,
			logic signed [15:0] sz);
		tilt_result_t r;
		longint mag, unused, ra, pa;
		acc_x += longint'(sx) - hist_x[slot_ptr];
		acc_y += longint'(sy) - hist_y[slot_ptr];
		acc_z += longint'(sz) - hist_z[slot_ptr];
		hist_x[slot_ptr] = sx;
		hist_y[slot_ptr] = sy;
		hist_z[slot_ptr] = sz;
		slot_ptr = (slot_ptr + 1) % WIN;
		if (held < WIN) held++;
		ra = cordic_angle(acc_z <<< PRE_SHIFT, acc_y <<< PRE_SHIFT, mag);
		pa = cordic_angle(mag, -(acc_x <<< PRE_SHIFT), unused);
		r.mx = 16'(acc_x / held);
		r.my = 16'(acc_y / held);
		r.mz = 16'(acc_z / held);
		r.roll = 16'(round_clamp(ra, 180));
		r.pitch = 15'(round_clamp(pa, 90));
		r.fill = 4'(held);
		pending_tilt.push_back(r);
	endtask

	// send one sample beat, bursts with random gaps; valid stays high inside a burst
	task automatic send_sample(logic signed [15:0] sx, logic signed [15:0] sy,
			logic signed [15:0] sz);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 8);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 60);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		sample_x <= sx;
		sample_y <= sy;
		sample_z <= sz;
		predict_tilt(sx, sy, sz);
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		beats_sent++;
	endtask

	// receiver stall pattern
	always @(posedge clk) begin
		if ($urandom_range(0, 199) == 0) stall_mode <= ~stall_mode;
		out_ready <= stall_mode ? ($urandom_range(0, 9) == 0) : ($urandom_range(0, 3) != 0);
	end

	// result checker
	always @(posedge clk) begin
		tilt_result_t e;
		if (arst_n && out_valid && out_ready) begin
			beats_seen++;
			if (pending_tilt.size() == 0) begin
				$display("%0t: unexpected result beat", $time);
				errors++;
			end else begin
				e = pending_tilt.pop_front();
				if (mean_x !== e.mx) begin
					$display("%0t: mean_x exp %0d got %0d", $time, e.mx, mean_x);
					errors++;
				end
				if (mean_y !== e.my) begin
					$display("%0t: mean_y exp %0d got %0d", $time, e.my, mean_y);
					errors++;
				end
				if (mean_z !== e.mz) begin
					$display("%0t: mean_z exp %0d got %0d", $time, e.mz, mean_z);
					errors++;
				end
				if (roll_angle !== e.roll) begin
					$display("%0t: roll exp %0d got %0d", $time, e.roll, roll_angle);
					errors++;
				end
				if (pitch_angle !== e.pitch) begin
					$display("%0t: pitch exp %0d got %0d", $time, e.pitch, pitch_angle);
					errors++;
				end
				if (samples_in_window !== e.fill) begin
					$display("%0t: fill exp %0d got %0d", $time, e.fill, samples_in_window);
					errors++;
				end
			end
		end
	end

	// zero vectors, axis extremes, left half plane and window fill/wrap
	task automatic test_directed();
		send_sample(16'sd0, 16'sd0, 16'sd0);
		send_sample(16'sd0, 16'sd0, 16'sd0);
		send_sample(16'sh7fff, 16'sh7fff, 16'sh7fff);
		send_sample(-16'sh8000, -16'sh8000, -16'sh8000);
		send_sample(16'sd0, 16'sd0, -16'sh8000);
		send_sample(16'sd0, 16'sd0, -16'sh8000);
		send_sample(16'sd0, 16'sd0, -16'sh8000);
		send_sample(16'sd0, 16'sd100, -16'sh8000);
		send_sample(16'sd0, -16'sd100, -16'sh8000);
		for (int i = 0; i < 8; i++) send_sample(16'sd0, 16'sd0, -16'sh8000);
		send_sample(16'sh7fff, 16'sd0, 16'sd0);
		send_sample(-16'sh8000, 16'sd0, 16'sd0);
		send_sample(16'sd0, 16'sh7fff, 16'sd0);
		send_sample(16'sd0, -16'sh8000, 16'sd0);
		send_sample(-16'sd1, -16'sd1, -16'sd1);
		send_sample(16'sd1, 16'sd1, 16'sd1);
		send_sample(16'sh5555, -16'sh5556, 16'sh2aaa);
	endtask

	// random samples: mostly gravity-like with noise, some full range, some within +-1
	task automatic test_random(int n);
		logic signed [15:0] gx, gy, gz;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 3) == 0) begin
				send_sample(16'($urandom), 16'($urandom), 16'($urandom));
			end else if ($urandom_range(0, 9) == 0) begin
				send_sample(16'($urandom_range(0, 2) - 1), 16'($urandom_range(0, 2) - 1),
					16'($urandom_range(0, 2) - 1));
			end else begin
				gx = $urandom_range(0, 1) ? 16'sh7fff : -16'sh8000;
				gy = 16'($urandom);
				gz = $urandom_range(0, 1) ? 16'sh7fff : -16'sh8000;
				send_sample(($urandom_range(0, 1) ? gx : 16'sh0000) ^ 16'($urandom_range(0, 255)),
					gy >>> $urandom_range(0, 15),
					gz ^ 16'($urandom_range(0, 4095)));
			end
		end
	endtask

	initial begin
		for (int i = 0; i < WIN; i++) begin
			hist_x[i] = 0; hist_y[i] = 0; hist_z[i] = 0;
		end
		acc_x = 0; acc_y = 0; acc_z = 0;
		slot_ptr = 0; held = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(750);
		in_valid <= 1'b0;
		while (pending_tilt.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		$display("sent %0d sample beats, checked %0d results", beats_sent, beats_seen);
		$display("covered zero vectors, axis extremes, left half plane and window wrap");
		if (errors == 0 && pending_tilt.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	initial begin
		#8000000;
		$display("timeout");
		$display("DONE: errors detected");
		$finish;
	end

endmodule

// ===== accel_tilt_moving_average_core.f =====
hdl/atm_pkg.sv
hdl/atm_ring.sv
hdl/atm_div.sv
hdl/atm_cordic.sv
hdl/accel_tilt_moving_average_core.sv
tb/tb_accel_tilt_moving_average_core.sv
